[src/deadline_job_table_admission_core_defines.svh]
// Assertion macros for the deadline job table.
`ifndef DEADLINE_JOB_TABLE_ADMISSION_CORE_DEFINES_SVH
`define DEADLINE_JOB_TABLE_ADMISSION_CORE_DEFINES_SVH

// Check an implication on every clock edge, off in reset.
`define DJTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check an implication in the next cycle, off in reset.
`define DJTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/djta_pkg.sv]
package djta_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int QUAR_DEF  = 4;
    localparam int TW        = 48;

    localparam logic [2:0] OP_SUBMIT  = 3'd0;
    localparam logic [2:0] OP_PASS    = 3'd1;
    localparam logic [2:0] OP_VISIT   = 3'd2;
    localparam logic [2:0] OP_REPORT  = 3'd3;
    localparam logic [2:0] OP_CANCEL  = 3'd4;
    localparam logic [2:0] OP_TAKE    = 3'd5;
    localparam logic [2:0] OP_RELEASE = 3'd6;
    localparam logic [2:0] OP_SUPER   = 3'd7;

    localparam logic [1:0] PH_FREE   = 2'd0;
    localparam logic [1:0] PH_ACTIVE = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [2:0] RS_NONE     = 3'd0;
    localparam logic [2:0] RS_DONE     = 3'd1;
    localparam logic [2:0] RS_FAILED   = 3'd2;
    localparam logic [2:0] RS_DEADLINE = 3'd3;
    localparam logic [2:0] RS_CANCEL   = 3'd4;
    localparam logic [2:0] RS_OVERRUN  = 3'd5;

    localparam logic [1:0] VA_NONE    = 2'd0;
    localparam logic [1:0] VA_EXPIRED = 2'd1;
    localparam logic [1:0] VA_DEFER   = 2'd2;
    localparam logic [1:0] VA_GRANT   = 2'd3;

    localparam logic [1:0] ST_PROGRESS = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_FAILED   = 2'd2;

    localparam logic [1:0] REG_PASS  = 2'd0;
    localparam logic [1:0] REG_MAXB  = 2'd1;
    localparam logic [1:0] REG_GRACE = 2'd2;

    localparam logic [23:0] GEN_MASK = 24'h00FFFFFF;

    // Shared 48-bit adder/subtracter request and result.
    typedef struct packed {
        logic [TW-1:0] a;
        logic [TW-1:0] b;
        logic          sub;
    } alu_req_t;

    typedef struct packed {
        logic [TW-1:0] sum;
        logic          carry;
    } alu_rsp_t;
endpackage

[src/djta_alu.sv]
module djta_alu (
    input  djta_pkg::alu_req_t req,
    output djta_pkg::alu_rsp_t rsp
);
    import djta_pkg::*;
    logic [TW:0] full;

    // Subtract as a + ~b + 1; carry set means a >= b.
    always_comb
    begin
        if (req.sub)
        begin
            full = {1'b0, req.a} + {1'b0, ~req.b} + {{TW{1'b0}}, 1'b1};
        end
        else
        begin
            full = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.sum   = full[TW-1:0];
        rsp.carry = full[TW];
    end
endmodule

[src/deadline_job_table_admission_core.sv]
// Deadline job table: SLOTS job slots with generation-tagged handles and a
// QUARANTINE_ENTRIES list of quarantined step ids. One word is taken when
// in_valid is high and in_stall is low; the result word is presented after
// a decode state and then the 48-bit add or compare steps that the opcode
// needs, all through the single shared adder, and in_stall stays high until
// the result word is taken, so no new word is taken before the last result
// word is taken. Visits use the most adder steps (deadline compare, pass-end
// compare, slack compare, return-by sum).
// Configuration writes take effect at once and must only occur while idle.
module deadline_job_table_admission_core
    import djta_pkg::*;
#(
    parameter int SLOTS              = djta_pkg::SLOTS_DEF,
    parameter int QUARANTINE_ENTRIES = djta_pkg::QUAR_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [47:0] now_ms,
    input  logic [31:0] job_handle,
    input  logic [3:0]  slot_index,
    input  logic [15:0] step_id,
    input  logic [15:0] step_budget,
    input  logic [31:0] job_timeout,
    input  logic [1:0]  cadence,
    input  logic [1:0]  step_status,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [31:0] out_handle,
    output logic [2:0]  job_reason,
    output logic [1:0]  visit_action,
    output logic [47:0] return_by_ms,
    output logic        pet_watchdog,
    output logic        was_quarantined,
    output logic        any_busy,
    output logic        wants_fast
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = (QUARANTINE_ENTRIES > 1) ? $clog2(QUARANTINE_ENTRIES) : 1;
    localparam logic [TW-1:0] MAX48 = {TW{1'b1}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_A1   = 3'd2;
    localparam logic [2:0] S_A2   = 3'd3;
    localparam logic [2:0] S_A3   = 3'd4;
    localparam logic [2:0] S_A4   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [15:0] pass_b_reg, maxb_reg, grace_reg;

    logic [1:0]  ph_reg   [SLOTS];
    logic [23:0] gen_reg  [SLOTS];
    logic [2:0]  rsn_reg  [SLOTS];
    logic        fast_reg [SLOTS];
    logic [15:0] bud_reg  [SLOTS];
    logic [47:0] dl_reg   [SLOTS];
    logic [15:0] stp_reg  [SLOTS];
    logic [15:0] q_reg    [QUARANTINE_ENTRIES];
    logic [47:0] pass_stop_reg, run_due_reg;
    logic        run_act_reg;

    // Latched input word.
    logic [2:0]  op_reg;
    logic [47:0] now_reg;
    logic [31:0] hdl_reg;
    logic [3:0]  si_reg;
    logic [15:0] step_reg;
    logic [15:0] bin_reg;
    logic [31:0] to_reg;
    logic [1:0]  cad_reg;
    logic [1:0]  sts_reg;

    // Decoded target and scratch.
    logic [SW-1:0] tgt_reg;
    logic          tvalid_reg;
    logic [47:0]   tmp_reg;

    // Result word.
    logic        ok_reg, pet_reg, quar_reg;
    logic [31:0] oh_reg;
    logic [2:0]  rs_reg;
    logic [1:0]  va_reg;
    logic [47:0] rb_reg;

    alu_req_t areq;
    alu_rsp_t arsp;

    djta_alu u_alu (.req(areq), .rsp(arsp));

    // Decode helpers (combinational scans over slot and quarantine state).
    logic          free_found;
    logic [SW-1:0] free_idx;
    logic          listed;
    logic          q_free_found;
    logic [QW-1:0] q_free_idx;
    logic          q_hit;
    logic [QW-1:0] q_hit_idx;
    logic          h_ok;
    logic [SW-1:0] h_idx;
    logic [7:0]    h_low;
    logic          si_ok;
    logic [SW-1:0] si_idx;
    logic          busy_c, fast_c;
    logic [15:0]   qstep;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (ph_reg[i] == PH_FREE)
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
        si_idx = SW'(si_reg);
        si_ok  = ({28'd0, si_reg} < 32'(SLOTS)) && (ph_reg[si_idx] == PH_ACTIVE);
        qstep = (op_reg == OP_REPORT) ? stp_reg[si_idx] : step_reg;
        listed       = 1'b0;
        q_hit        = 1'b0;
        q_hit_idx    = '0;
        q_free_found = 1'b0;
        q_free_idx   = '0;
        for (int i = QUARANTINE_ENTRIES - 1; i >= 0; i--)
        begin
            if (q_reg[i] == qstep && qstep != 16'd0)
            begin
                listed    = 1'b1;
                q_hit     = 1'b1;
                q_hit_idx = QW'(i);
            end
            if (q_reg[i] == 16'd0)
            begin
                q_free_found = 1'b1;
                q_free_idx   = QW'(i);
            end
        end
        h_low = hdl_reg[7:0];
        h_idx = SW'(h_low - 8'd1);
        h_ok  = (h_low != 8'd0) && ({24'd0, h_low} <= 32'(SLOTS))
                && (ph_reg[h_idx] != PH_FREE)
                && ((gen_reg[h_idx] & GEN_MASK) == hdl_reg[31:8]);
        busy_c = 1'b0;
        fast_c = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (ph_reg[i] == PH_ACTIVE)
            begin
                busy_c = 1'b1;
                fast_c = fast_c | fast_reg[i];
            end
        end
    end

    // Adder operand selection per step.
    always_comb
    begin
        areq = '0;
        case (state_reg)
            S_A1:
            begin
                case (op_reg)
                    OP_SUBMIT: areq = '{a: now_reg, b: {16'd0, to_reg}, sub: 1'b0};
                    OP_PASS:   areq = '{a: now_reg, b: {32'd0, pass_b_reg}, sub: 1'b0};
                    OP_VISIT:  areq = '{a: now_reg, b: dl_reg[tgt_reg], sub: 1'b1};
                    OP_REPORT: areq = '{a: run_due_reg, b: now_reg, sub: 1'b1};
                    OP_SUPER:  areq = '{a: now_reg, b: run_due_reg, sub: 1'b1};
                    default:   areq = '0;
                endcase
            end
            S_A2:
            begin
                if (op_reg == OP_VISIT)
                begin
                    areq = '{a: pass_stop_reg, b: now_reg, sub: 1'b1};
                end
                else
                begin
                    areq = '{a: tmp_reg, b: {32'd0, grace_reg}, sub: 1'b1};
                end
            end
            S_A3:    areq = '{a: tmp_reg, b: {32'd0, bud_reg[tgt_reg]}, sub: 1'b1};
            S_A4:    areq = '{a: now_reg, b: {32'd0, bud_reg[tgt_reg]}, sub: 1'b0};
            default: areq = '0;
        endcase
    end

    logic [47:0] sat_sum;
    assign sat_sum = arsp.carry ? MAX48 : arsp.sum;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_DEC;
            S_DEC:   state_next = S_A1;
            S_A1:    state_next = S_OUT;
            S_A2:    state_next = S_OUT;
            S_A3:    state_next = S_OUT;
            S_A4:    state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_A1)
        begin
            if (op_reg == OP_VISIT && tvalid_reg && !arsp.carry) state_next = S_A2;
            if (op_reg == OP_SUPER && run_act_reg && arsp.carry
                && arsp.sum != 48'd0) state_next = S_A2;
        end
        if (state_reg == S_A2 && op_reg == OP_VISIT && arsp.carry
            && arsp.sum != 48'd0)
            state_next = S_A3;
        if (state_reg == S_A3 && arsp.carry) state_next = S_A4;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_b_reg    <= 16'd10;
            maxb_reg      <= 16'd10;
            grace_reg     <= 16'd5;
            pass_stop_reg <= '0;
            run_due_reg   <= '0;
            run_act_reg   <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                ph_reg[i]   <= PH_FREE;
                gen_reg[i]  <= 24'd1;
                rsn_reg[i]  <= RS_NONE;
                fast_reg[i] <= 1'b0;
            end
            for (int i = 0; i < QUARANTINE_ENTRIES; i++)
            begin
                q_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PASS:  pass_b_reg <= cfg_data;
                    REG_MAXB:  maxb_reg   <= cfg_data;
                    REG_GRACE: grace_reg  <= cfg_data;
                    default:   ;
                endcase
            end
            case (state_reg)
                S_DEC:
                begin
                    case (op_reg)
                        OP_SUBMIT:
                        begin
                            tgt_reg    <= free_idx;
                            tvalid_reg <= free_found && step_reg != 16'd0
                                && bin_reg != 16'd0 && bin_reg <= maxb_reg
                                && to_reg != 32'd0 && cad_reg <= 2'd1 && !listed;
                        end
                        OP_VISIT, OP_REPORT:
                        begin
                            tgt_reg    <= si_idx;
                            tvalid_reg <= si_ok;
                        end
                        OP_CANCEL:
                        begin
                            tgt_reg    <= h_idx;
                            tvalid_reg <= h_ok && ph_reg[h_idx] == PH_ACTIVE;
                        end
                        OP_TAKE:
                        begin
                            tgt_reg    <= h_idx;
                            tvalid_reg <= h_ok && ph_reg[h_idx] == PH_DONE;
                        end
                        default:
                        begin
                            tgt_reg    <= '0;
                            tvalid_reg <= 1'b0;
                        end
                    endcase
                end
                S_A1:
                begin
                    case (op_reg)
                        OP_SUBMIT:
                        begin
                            if (tvalid_reg)
                            begin
                                ph_reg[tgt_reg]   <= PH_ACTIVE;
                                rsn_reg[tgt_reg]  <= RS_NONE;
                                fast_reg[tgt_reg] <= cad_reg[0];
                                ok_reg <= 1'b1;
                                oh_reg <= {gen_reg[tgt_reg], 8'(32'(tgt_reg) + 1)};
                            end
                        end
                        OP_PASS:
                        begin
                            pass_stop_reg <= sat_sum;
                            ok_reg        <= 1'b1;
                        end
                        OP_VISIT:
                        begin
                            if (tvalid_reg)
                            begin
                                ok_reg <= 1'b1;
                                if (arsp.carry)
                                begin
                                    ph_reg[tgt_reg]  <= PH_DONE;
                                    rsn_reg[tgt_reg] <= RS_DEADLINE;
                                    va_reg <= VA_EXPIRED;
                                    rs_reg <= RS_DEADLINE;
                                end
                                else
                                begin
                                    va_reg <= VA_DEFER;
                                    rs_reg <= rsn_reg[tgt_reg];
                                end
                            end
                        end
                        OP_REPORT:
                        begin
                            if (tvalid_reg && run_act_reg)
                            begin
                                run_act_reg <= 1'b0;
                                ok_reg      <= 1'b1;
                                if (!arsp.carry)
                                begin
                                    // Late: quarantine the step and end overrun.
                                    if (!listed && qstep != 16'd0 && q_free_found)
                                        q_reg[q_free_idx] <= qstep;
                                    ph_reg[tgt_reg]  <= PH_DONE;
                                    rsn_reg[tgt_reg] <= RS_OVERRUN;
                                    rs_reg   <= RS_OVERRUN;
                                    quar_reg <= 1'b1;
                                end
                                else
                                begin
                                    case (sts_reg)
                                        ST_PROGRESS:
                                        begin
                                            pet_reg <= 1'b1;
                                            rs_reg  <= rsn_reg[tgt_reg];
                                        end
                                        ST_DONE:
                                        begin
                                            pet_reg          <= 1'b1;
                                            ph_reg[tgt_reg]  <= PH_DONE;
                                            rsn_reg[tgt_reg] <= RS_DONE;
                                            rs_reg           <= RS_DONE;
                                        end
                                        ST_FAILED:
                                        begin
                                            ph_reg[tgt_reg]  <= PH_DONE;
                                            rsn_reg[tgt_reg] <= RS_FAILED;
                                            rs_reg           <= RS_FAILED;
                                        end
                                        default: rs_reg <= rsn_reg[tgt_reg];
                                    endcase
                                end
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (tvalid_reg)
                            begin
                                ph_reg[tgt_reg]  <= PH_DONE;
                                rsn_reg[tgt_reg] <= RS_CANCEL;
                                ok_reg <= 1'b1;
                                rs_reg <= RS_CANCEL;
                            end
                        end
                        OP_TAKE:
                        begin
                            if (tvalid_reg)
                            begin
                                ok_reg <= 1'b1;
                                rs_reg <= rsn_reg[tgt_reg];
                                ph_reg[tgt_reg]   <= PH_FREE;
                                rsn_reg[tgt_reg]  <= RS_NONE;
                                fast_reg[tgt_reg] <= 1'b0;
                                gen_reg[tgt_reg]  <= (gen_reg[tgt_reg] + 24'd1) & GEN_MASK;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (q_hit)
                            begin
                                q_reg[q_hit_idx] <= '0;
                                ok_reg <= 1'b1;
                            end
                        end
                        default: tmp_reg <= arsp.sum;
                    endcase
                end
                S_A2:
                begin
                    if (op_reg == OP_VISIT)
                    begin
                        tmp_reg <= arsp.sum;
                    end
                    else
                    begin
                        ok_reg <= arsp.carry;
                    end
                end
                S_A4:
                begin
                    rb_reg      <= sat_sum;
                    run_due_reg <= sat_sum;
                    run_act_reg <= 1'b1;
                    va_reg      <= VA_GRANT;
                end
                default: ;
            endcase
            if (state_reg == S_IDLE && in_valid)
            begin
                ok_reg   <= 1'b0;
                oh_reg   <= '0;
                rs_reg   <= RS_NONE;
                va_reg   <= VA_NONE;
                rb_reg   <= '0;
                pet_reg  <= 1'b0;
                quar_reg <= 1'b0;
            end
        end
    end

    // Deadline, budget and step payloads carry no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg   <= opcode;
            now_reg  <= now_ms;
            hdl_reg  <= job_handle;
            si_reg   <= slot_index;
            step_reg <= step_id;
            bin_reg  <= step_budget;
            to_reg   <= job_timeout;
            cad_reg  <= cadence;
            sts_reg  <= step_status;
        end
        if (state_reg == S_A1 && op_reg == OP_SUBMIT && tvalid_reg)
        begin
            bud_reg[tgt_reg] <= bin_reg;
            dl_reg[tgt_reg]  <= sat_sum;
            stp_reg[tgt_reg] <= step_reg;
        end
    end

    assign ok              = ok_reg;
    assign out_handle      = oh_reg;
    assign job_reason      = rs_reg;
    assign visit_action    = va_reg;
    assign return_by_ms    = rb_reg;
    assign pet_watchdog    = pet_reg;
    assign was_quarantined = quar_reg;
    assign any_busy        = busy_c;
    assign wants_fast      = fast_c;
endmodule

[src/djta_checker.sv]
`include "deadline_job_table_admission_core_defines.svh"

module djta_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        ok,
    input logic [31:0] out_handle,
    input logic [1:0]  visit_action,
    input logic [47:0] return_by_ms,
    input logic        any_busy,
    input logic        wants_fast
);
    import djta_pkg::*;

    `DJTA_ASSERT_IMP(a_fast_busy, clk, rst_n, out_valid && wants_fast, any_busy)
    `DJTA_ASSERT_IMP(a_busy_out, clk, rst_n, out_valid, in_stall)
    `DJTA_ASSERT_IMP(a_handle_ok, clk, rst_n, out_valid && out_handle != 32'd0, ok)
    `DJTA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(return_by_ms))
    `DJTA_ASSERT_IMP(a_rb_grant, clk, rst_n, out_valid && return_by_ms != 48'd0, visit_action == VA_GRANT)
endmodule

bind deadline_job_table_admission_core djta_checker u_djta_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok),
    .out_handle(out_handle), .visit_action(visit_action),
    .return_by_ms(return_by_ms), .any_busy(any_busy), .wants_fast(wants_fast)
);
